/* sv/ps2_mouse_packet_tracker_assert.svh */
// Assertion macros for the PS/2 mouse packet tracker.
// Each macro checks a property on the rising clock edge, disabled while reset is low.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

`define PMPT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define PMPT_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define PMPT_ASSERT(lbl, clk, rstn, prop, msg)

`define PMPT_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* sv/pmpt_pkg.sv */
`timescale 1ns / 1ps

package pmpt_pkg;

  // Coordinate width default and configuration register width
  localparam int CoordBitsDefault = 12;
  localparam int CfgW             = 13;
  localparam int CfgAddrW         = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgScreenWidth   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgScreenHeight  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgDeliverEnable = 2'd2;

  // Configuration reset values
  localparam logic [CfgW-1:0] ScreenWidthReset  = 13'd640;
  localparam logic [CfgW-1:0] ScreenHeightReset = 13'd480;

  // Header byte bits
  localparam logic [7:0] HdrYOverflow = 8'h80;
  localparam logic [7:0] HdrXOverflow = 8'h40;
  localparam logic [7:0] HdrSync      = 8'h08;
  localparam logic [7:0] HdrMiddle    = 8'h04;
  localparam logic [7:0] HdrRight     = 8'h02;
  localparam logic [7:0] HdrLeft      = 8'h01;
  localparam logic [7:0] HdrButtons   = HdrLeft | HdrRight | HdrMiddle;
  localparam logic [7:0] HdrOverflow  = HdrXOverflow | HdrYOverflow;

endpackage

/* sv/ps2_mouse_packet_tracker.sv */
`timescale 1ns / 1ps

// Channel    Dir  Payload (lowest bit first)
// s_axis     in   tdata: data_byte[7:0]; tuser: aux_flag
// m_axis     out  tdata: delta_x, delta_y, button_bits, cursor_x, cursor_y, queued
// cfg        in   cfg_we_i / cfg_addr_i / cfg_wdata_i, single-cycle register write
//
// One byte is taken every cycle while s_axis_tready is high; from the input register, a good
// packet's third byte loads the result register and m_axis_tvalid, unless results still wait.
// The input register feeds the framing and add-clamp logic, which fills a result register.
// A skid register behind the result register lets input flow while a result waits.
// Reset clears framing phase, cursor and valid flags and loads the configuration defaults.
// Input stalls only when both result and skid registers are full and the stage holds a byte.

module ps2_mouse_packet_tracker
  import pmpt_pkg::*;
#(
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  // byte stream from the controller
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // data_byte[7:0]
  input  logic                 s_axis_tuser,  // aux_flag
  // packet results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // delta_x[7:0], delta_y[15:8], button_bits[18:16], cursor_x, cursor_y, queued, zero pad
  output logic [((2*CoordBits+20+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OutW     = 2 * CoordBits + 20;
  localparam int OutPadW  = ((OutW + 7) / 8) * 8;
  localparam int SumW     = ((CoordBits > CfgW) ? CoordBits : CfgW) + 2;
  localparam logic signed [SumW-1:0] CoordMax = SumW'({CoordBits{1'b1}});

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_X,
    PH_Y
  } phase_e;

  typedef struct packed {
    logic                 queued;
    logic [CoordBits-1:0] cursor_y;
    logic [CoordBits-1:0] cursor_x;
    logic [2:0]           button_bits;
    logic signed [7:0]    delta_y;
    logic signed [7:0]    delta_x;
  } result_t;

  // Move a coordinate by a signed delta and clamp to [0, size-1], capped at the largest coordinate
  function automatic logic [CoordBits-1:0] move_clamp(
    logic [CoordBits-1:0]   pos,
    logic signed [SumW-1:0] delta,
    logic [CfgW-1:0]        size
  );
    logic [CfgW-1:0]        lim_raw;
    logic signed [SumW-1:0] lim;
    logic signed [SumW-1:0] p;
    lim_raw = (size == '0) ? '0 : size - CfgW'(1);
    lim     = $signed(SumW'(lim_raw));
    if (lim > CoordMax) lim = CoordMax;
    p = $signed(SumW'(pos)) + delta;
    if (p < 0) p = '0;
    if (p >= lim) p = lim;
    return p[CoordBits-1:0];
  endfunction

  // configuration
  logic [CfgW-1:0] width_q, height_q;
  logic            deliver_q;

  // input stage
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_aux_q;

  // framing and cursor state
  phase_e               phase_q;
  logic [7:0]           header_q;
  logic [7:0]           x_q;
  logic [CoordBits-1:0] pos_x_q, pos_y_q;

  // result and skid registers
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    stage_fire;
  logic    has_result;
  logic    pop;
  logic    push;
  result_t res;
  logic [CoordBits-1:0] new_x, new_y;

  // Compute the packet result from the staged byte
  always_comb begin
    has_result = in_aux_q && (phase_q == PH_Y) && ((header_q & HdrOverflow) == '0);
    new_x = move_clamp(pos_x_q, SumW'($signed(x_q)), width_q);
    new_y = move_clamp(pos_y_q, -(SumW'($signed(in_byte_q))), height_q);
    res.delta_x     = $signed(x_q);
    res.delta_y     = $signed(in_byte_q);
    res.button_bits = header_q[2:0] & HdrButtons[2:0];
    res.cursor_x    = new_x;
    res.cursor_y    = new_y;
    res.queued      = deliver_q;
  end

  assign stage_fire    = in_valid_q && !skid_valid_q;
  assign s_axis_tready = !in_valid_q || stage_fire;
  assign pop           = out_valid_q && m_axis_tready;
  assign push          = stage_fire && has_result;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutPadW'(out_q);

  // Hold configuration, input, framing state, cursor and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ScreenWidthReset;
      height_q     <= ScreenHeightReset;
      deliver_q    <= 1'b0;
      in_valid_q   <= 1'b0;
      in_byte_q    <= '0;
      in_aux_q     <= 1'b0;
      phase_q      <= PH_HEADER;
      header_q     <= '0;
      x_q          <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgScreenWidth:   width_q   <= cfg_wdata_i;
          CfgScreenHeight:  height_q  <= cfg_wdata_i;
          CfgDeliverEnable: deliver_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      // capture an incoming byte
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
        if (s_axis_tvalid) begin
          in_byte_q <= s_axis_tdata;
          in_aux_q  <= s_axis_tuser;
        end
      end

      // advance framing on aux bytes; drop the rest
      if (stage_fire && in_aux_q) begin
        unique case (phase_q)
          PH_X: begin
            x_q     <= in_byte_q;
            phase_q <= PH_Y;
          end
          PH_Y: begin
            phase_q <= PH_HEADER;
            if (has_result) begin
              pos_x_q <= new_x;
              pos_y_q <= new_y;
            end
          end
          default: begin
            header_q <= in_byte_q;
            phase_q  <= ((in_byte_q & HdrSync) != '0) ? PH_X : PH_HEADER;
          end
        endcase
      end

      // result register with skid
      if (skid_valid_q) begin
        if (pop) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_q || pop) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`include "ps2_mouse_packet_tracker_assert.svh"

  `PMPT_ASSERT(a_skid_needs_out, clk_i, rst_ni,
               skid_valid_q |-> out_valid_q, "skid full while result register empty")
  `PMPT_ASSERT(a_stall_cause, clk_i, rst_ni,
               !s_axis_tready |-> (in_valid_q && skid_valid_q), "input stalled without cause")
  `PMPT_ASSERT(a_result_framed, clk_i, rst_ni,
               push |-> (in_aux_q && phase_q == PH_Y && (header_q & HdrOverflow) == '0),
               "result outside a good packet")
  `PMPT_ASSERT_NEVER(a_skid_overwrite, clk_i, rst_ni,
                     skid_valid_q && push, "result pushed while skid is full")

endmodule
